// File: hw/rtl/durp_pkg.sv
`default_nettype none

package durp_pkg;

  // Kept fraction digits. The datapath splits them into two groups of nine.
  localparam int FracDigits = 18;
  localparam int UnitBytes  = 3;

  // Scale pipeline layout: four partial-product steps. Beside them the scaled
  // low fraction group is divided by 1e9 with a reciprocal estimate and one
  // correction step. The final sum comes last.
  localparam int DivEst      = 2;
  localparam int DivFix      = DivEst + 1;
  localparam int SumStage    = 5;
  localparam int ScaleStages = SumStage + 1;

  localparam logic [2:0] StatusOk       = 3'd0;
  localparam logic [2:0] StatusEmpty    = 3'd1;
  localparam logic [2:0] StatusNeedNum  = 3'd2;
  localparam logic [2:0] StatusDigitOvf = 3'd3;
  localparam logic [2:0] StatusEmptyNum = 3'd4;
  localparam logic [2:0] StatusBadUnit  = 3'd5;
  localparam logic [2:0] StatusSumOvf   = 3'd6;

  localparam logic [63:0] MaxPos  = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] TopBit  = 64'h8000_0000_0000_0000;
  localparam logic [42:0] FracDiv = 43'd1000000000;
  // floor(2^52 / 1e9), applied to the dividend shifted right by 20.
  localparam logic [22:0] RecipMul = 23'd4503599;

  typedef enum logic [2:0] {
    UnitBad,
    UnitNs,
    UnitUs,
    UnitMs,
    UnitSec,
    UnitMin,
    UnitHour
  } unit_e;

  // One finished component and/or the end of a string.
  typedef struct packed {
    logic        last;
    logic        comp;
    logic [2:0]  ferr;
    logic        neg;
    logic [62:0] ival;
    logic [41:0] uval;
    logic [11:0] cmul;
    logic [29:0] base;
    logic [29:0] b9;
  } tok_t;

  // Scaled component leaving the pipeline.
  typedef struct packed {
    logic        last;
    logic        comp;
    logic [2:0]  ferr;
    logic        neg;
    logic [62:0] mag;
    logic        ovf;
  } res_t;

  function automatic logic [29:0] pow10(input logic [3:0] k);
    logic [29:0] p;
    case (k)
      4'd0: p = 30'd1;
      4'd1: p = 30'd10;
      4'd2: p = 30'd100;
      4'd3: p = 30'd1000;
      4'd4: p = 30'd10000;
      4'd5: p = 30'd100000;
      4'd6: p = 30'd1000000;
      4'd7: p = 30'd10000000;
      4'd8: p = 30'd100000000;
      default: p = 30'd0;
    endcase
    return p;
  endfunction

  // Digit d placed k decimal places above the units position.
  function automatic logic [29:0] frac_term(input logic [3:0] d, input logic [3:0] k);
    logic [33:0] p;
    p = {30'd0, d} * {4'd0, pow10(k)};
    return p[29:0];
  endfunction

  function automatic unit_e unit_decode(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [2:0] len);
    unit_e u;
    u = UnitBad;
    if (len == 3'd1) begin
      if (b0 == "s") u = UnitSec;
      else if (b0 == "m") u = UnitMin;
      else if (b0 == "h") u = UnitHour;
    end else if (len == 3'd2 && b1 == "s") begin
      if (b0 == "n") u = UnitNs;
      else if (b0 == "u") u = UnitUs;
      else if (b0 == "m") u = UnitMs;
    end else if (len == 3'd3 && b2 == "s") begin
      // Both UTF-8 spellings of the micro sign.
      if ((b0 == 8'hc2 && b1 == 8'hb5) || (b0 == 8'hce && b1 == 8'hbc)) u = UnitUs;
    end
    return u;
  endfunction

  function automatic logic [41:0] unit_scale(input unit_e u);
    logic [41:0] v;
    case (u)
      UnitNs:   v = 42'd1;
      UnitUs:   v = 42'd1000;
      UnitMs:   v = 42'd1000000;
      UnitSec:  v = 42'd1000000000;
      UnitMin:  v = 42'd60000000000;
      UnitHour: v = 42'd3600000000000;
      default:  v = 42'd0;
    endcase
    return v;
  endfunction

  function automatic logic [11:0] unit_cmul(input unit_e u);
    logic [11:0] c;
    case (u)
      UnitMin:  c = 12'd60;
      UnitHour: c = 12'd3600;
      default:  c = 12'd1;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/duration_string_parser.sv
// Throughput: one byte per cycle while in_ready_o is high; the 6-stage scale pipeline then
// takes a new component every cycle, and each string result leaves through the output register.
// Input ready drops only while a finished string at the pipeline end waits for a full output.
// Reset: rst_ni is asynchronous and active low; it clears the parser, pipeline valids, the
// running sum and the output valid at once, with no clearing pass.
`default_nettype none

module duration_string_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    char_in_i,
  input  wire logic          has_char_i,
  input  wire logic          last_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic signed [63:0] nanoseconds_o,
  output logic [2:0]         status_o
);

  logic           adv;
  logic           take;
  logic           tok_vld;
  durp_pkg::tok_t tok;
  logic           res_vld;
  durp_pkg::res_t res;

  assign in_ready_o = adv;
  assign take       = in_valid_i && adv;

  durp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .char_in_i  (char_in_i),
    .has_char_i (has_char_i),
    .last_i     (last_i),
    .tok_vld_o  (tok_vld),
    .tok_o      (tok)
  );

  durp_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .tok_vld_i (tok_vld),
    .tok_i     (tok),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  durp_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_vld_i     (res_vld),
    .res_i         (res),
    .out_ready_i   (out_ready_i),
    .adv_o         (adv),
    .out_valid_o   (out_valid_o),
    .nanoseconds_o (nanoseconds_o),
    .status_o      (status_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/durp_front.sv
`default_nettype none

module durp_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           take_i,
  input  wire logic [7:0]     char_in_i,
  input  wire logic           has_char_i,
  input  wire logic           last_i,
  output logic                tok_vld_o,
  output durp_pkg::tok_t      tok_o
);

  localparam logic [2:0] PhStart = 3'd0;
  localparam logic [2:0] PhComp  = 3'd1;
  localparam logic [2:0] PhInt   = 3'd2;
  localparam logic [2:0] PhFrac  = 3'd3;
  localparam logic [2:0] PhUnit  = 3'd4;
  localparam logic [2:0] PhErr   = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic        neg_q, neg_d;
  logic [62:0] ival_q, ival_d;
  logic        dseen_q, dseen_d;
  logic        lzero_q, lzero_d;
  logic [7:0]  ubyte_q [durp_pkg::UnitBytes];
  logic [7:0]  ubyte_d [durp_pkg::UnitBytes];
  logic [2:0]  ulen_q, ulen_d;
  logic [9:0]  a3_q, a3_d;
  logic [19:0] a6_q, a6_d;
  logic [29:0] a9_q, a9_d;
  logic [29:0] b9_q, b9_d;
  logic [4:0]  fcnt_q, fcnt_d;
  logic [2:0]  ferr_q, ferr_d;

  always_comb begin
    logic [2:0]      ph;
    logic            skip;
    logic            isdig;
    logic [3:0]      dig;
    logic [66:0]     mul10;
    logic [4:0]      kk;
    logic [29:0]     ft;
    logic            fin_dig;
    logic            fin_end;
    durp_pkg::unit_e ucode;
    logic [62:0]     c_ival;
    logic [9:0]      c_a3;
    logic [19:0]     c_a6;
    logic [29:0]     c_a9;
    logic [29:0]     c_b9;
    logic [2:0]      t_ferr;
    logic            t_neg;

    phase_d = phase_q;
    neg_d   = neg_q;
    ival_d  = ival_q;
    dseen_d = dseen_q;
    lzero_d = lzero_q;
    ubyte_d = ubyte_q;
    ulen_d  = ulen_q;
    a3_d    = a3_q;
    a6_d    = a6_q;
    a9_d    = a9_q;
    b9_d    = b9_q;
    fcnt_d  = fcnt_q;
    ferr_d  = ferr_q;

    ph      = phase_q;
    skip    = 1'b0;
    isdig   = (char_in_i >= "0") && (char_in_i <= "9");
    dig     = char_in_i[3:0];
    mul10   = ({4'd0, ival_q} << 3) + ({4'd0, ival_q} << 1) + {63'd0, dig};
    kk      = 5'd0;
    ft      = 30'd0;
    fin_dig = 1'b0;
    fin_end = 1'b0;
    ucode   = durp_pkg::UnitBad;
    c_ival  = ival_q;
    c_a3    = a3_q;
    c_a6    = a6_q;
    c_a9    = a9_q;
    c_b9    = b9_q;
    t_ferr  = durp_pkg::StatusOk;
    t_neg   = 1'b0;

    if (has_char_i) begin
      if (ph == PhStart) begin
        ph      = PhComp;
        phase_d = PhComp;
        if (char_in_i == "+" || char_in_i == "-") begin
          neg_d = (char_in_i == "-");
          skip  = 1'b1;
        end
      end
      if (!skip) begin
        case (ph)
          PhComp: begin
            if (isdig) begin
              phase_d = PhInt;
              dseen_d = 1'b1;
              lzero_d = (dig == 4'd0);
              ival_d  = {59'd0, dig};
            end else if (char_in_i == ".") begin
              phase_d = PhFrac;
            end else begin
              ferr_d  = durp_pkg::StatusNeedNum;
              phase_d = PhErr;
            end
          end
          PhInt: begin
            lzero_d = 1'b0;
            if (isdig) begin
              if (|mul10[66:63]) begin
                ferr_d  = durp_pkg::StatusDigitOvf;
                phase_d = PhErr;
              end else begin
                ival_d = mul10[62:0];
              end
            end else if (char_in_i == ".") begin
              phase_d = PhFrac;
            end else begin
              if (ulen_q < 3'(durp_pkg::UnitBytes)) ubyte_d[ulen_q[1:0]] = char_in_i;
              if (ulen_q <= 3'(durp_pkg::UnitBytes)) ulen_d = ulen_q + 3'd1;
              phase_d = PhUnit;
            end
          end
          PhFrac: begin
            if (isdig) begin
              if (fcnt_q < 5'(durp_pkg::FracDigits)) begin
                // Each digit lands in every prefix group that still has room.
                if (fcnt_q < 5'd3) begin
                  kk   = 5'd2 - fcnt_q;
                  ft   = durp_pkg::frac_term(dig, kk[3:0]);
                  a3_d = a3_q + ft[9:0];
                end
                if (fcnt_q < 5'd6) begin
                  kk   = 5'd5 - fcnt_q;
                  ft   = durp_pkg::frac_term(dig, kk[3:0]);
                  a6_d = a6_q + ft[19:0];
                end
                if (fcnt_q < 5'd9) begin
                  kk   = 5'd8 - fcnt_q;
                  a9_d = a9_q + durp_pkg::frac_term(dig, kk[3:0]);
                end else begin
                  kk   = 5'd17 - fcnt_q;
                  b9_d = b9_q + durp_pkg::frac_term(dig, kk[3:0]);
                end
                fcnt_d = fcnt_q + 5'd1;
              end
            end else if (!dseen_q && ival_q == 63'd0 && a9_q == 30'd0 && b9_q == 30'd0) begin
              ferr_d  = durp_pkg::StatusEmptyNum;
              phase_d = PhErr;
            end else begin
              if (ulen_q < 3'(durp_pkg::UnitBytes)) ubyte_d[ulen_q[1:0]] = char_in_i;
              if (ulen_q <= 3'(durp_pkg::UnitBytes)) ulen_d = ulen_q + 3'd1;
              phase_d = PhUnit;
            end
          end
          PhUnit: begin
            if (isdig) begin
              // A digit closes the component and opens the next one, or flags a bad unit.
              ucode = durp_pkg::unit_decode(ubyte_q[0], ubyte_q[1], ubyte_q[2], ulen_q);
              if (ucode == durp_pkg::UnitBad) begin
                ferr_d  = durp_pkg::StatusBadUnit;
                phase_d = PhErr;
              end else begin
                fin_dig = 1'b1;
                a3_d    = 10'd0;
                a6_d    = 20'd0;
                a9_d    = 30'd0;
                b9_d    = 30'd0;
                fcnt_d  = 5'd0;
                ulen_d  = 3'd0;
                phase_d = PhInt;
                dseen_d = 1'b1;
                lzero_d = (dig == 4'd0);
                ival_d  = {59'd0, dig};
              end
            end else begin
              if (ulen_q < 3'(durp_pkg::UnitBytes)) ubyte_d[ulen_q[1:0]] = char_in_i;
              if (ulen_q <= 3'(durp_pkg::UnitBytes)) ulen_d = ulen_q + 3'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (!fin_dig) begin
      c_ival = ival_d;
      c_a3   = a3_d;
      c_a6   = a6_d;
      c_a9   = a9_d;
      c_b9   = b9_d;
    end

    if (last_i) begin
      t_ferr = ferr_d;
      t_neg  = neg_d;
      case (phase_d)
        PhStart: t_ferr = durp_pkg::StatusEmpty;
        PhComp:  t_ferr = durp_pkg::StatusNeedNum;
        PhInt: begin
          if (!lzero_d) t_ferr = durp_pkg::StatusBadUnit;
        end
        PhFrac: begin
          if (!dseen_d && ival_d == 63'd0 && a9_d == 30'd0 && b9_d == 30'd0) begin
            t_ferr = durp_pkg::StatusEmptyNum;
          end else begin
            t_ferr = durp_pkg::StatusBadUnit;
          end
        end
        PhUnit: begin
          ucode = durp_pkg::unit_decode(ubyte_d[0], ubyte_d[1], ubyte_d[2], ulen_d);
          if (ucode == durp_pkg::UnitBad) t_ferr = durp_pkg::StatusBadUnit;
          else fin_end = 1'b1;
        end
        default: begin
        end
      endcase
      phase_d = PhStart;
      neg_d   = 1'b0;
      ival_d  = 63'd0;
      dseen_d = 1'b0;
      lzero_d = 1'b0;
      ulen_d  = 3'd0;
      a3_d    = 10'd0;
      a6_d    = 20'd0;
      a9_d    = 30'd0;
      b9_d    = 30'd0;
      fcnt_d  = 5'd0;
      ferr_d  = durp_pkg::StatusOk;
    end

    tok_vld_o    = take_i && (fin_dig || fin_end || last_i);
    tok_o.last   = last_i;
    tok_o.comp   = fin_dig || fin_end;
    tok_o.ferr   = t_ferr;
    tok_o.neg    = t_neg;
    tok_o.ival   = c_ival;
    tok_o.uval   = durp_pkg::unit_scale(ucode);
    tok_o.cmul   = durp_pkg::unit_cmul(ucode);
    case (ucode)
      durp_pkg::UnitUs:   tok_o.base = {20'd0, c_a3};
      durp_pkg::UnitMs:   tok_o.base = {10'd0, c_a6};
      durp_pkg::UnitSec,
      durp_pkg::UnitMin,
      durp_pkg::UnitHour: tok_o.base = c_a9;
      default:            tok_o.base = 30'd0;
    endcase
    tok_o.b9 = (ucode == durp_pkg::UnitMin || ucode == durp_pkg::UnitHour) ? c_b9 : 30'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      neg_q   <= 1'b0;
      ival_q  <= 63'd0;
      dseen_q <= 1'b0;
      lzero_q <= 1'b0;
      ulen_q  <= 3'd0;
      a3_q    <= 10'd0;
      a6_q    <= 20'd0;
      a9_q    <= 30'd0;
      b9_q    <= 30'd0;
      fcnt_q  <= 5'd0;
      ferr_q  <= durp_pkg::StatusOk;
    end else if (take_i) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      ival_q  <= ival_d;
      dseen_q <= dseen_d;
      lzero_q <= lzero_d;
      ulen_q  <= ulen_d;
      a3_q    <= a3_d;
      a6_q    <= a6_d;
      a9_q    <= a9_d;
      b9_q    <= b9_d;
      fcnt_q  <= fcnt_d;
      ferr_q  <= ferr_d;
    end
  end

  // Unit bytes are only read after being written for the current component.
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      ubyte_q <= ubyte_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/durp_scale.sv
`default_nettype none

module durp_scale (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  wire logic           tok_vld_i,
  input  wire durp_pkg::tok_t tok_i,
  output logic                res_vld_o,
  output durp_pkg::res_t      res_o
);

  localparam int NumStages = durp_pkg::ScaleStages;

  typedef struct packed {
    logic        last;
    logic        comp;
    logic [2:0]  ferr;
    logic        neg;
    logic [62:0] ival;
    logic [41:0] uval;
    logic [11:0] cmul;
    logic [29:0] base;
    logic [29:0] b9;
    logic [42:0] rem;
    logic [11:0] quo;
    logic [41:0] cbase;
    logic [62:0] prod;
    logic        povf;
  } stage_t;

  logic [NumStages-1:0] vld_q;
  stage_t               st_q [NumStages];
  stage_t               st_d [NumStages];

  always_comb begin
    logic [31:0]  ma;
    logic [20:0]  mb;
    logic [52:0]  pp;
    logic [116:0] term;
    logic [64:0]  acc;
    logic [44:0]  rp;
    logic [42:0]  pq;
    logic [42:0]  rr;
    logic [63:0]  fsum;

    ma   = 32'd0;
    mb   = 21'd0;
    pp   = 53'd0;
    term = 117'd0;
    acc  = 65'd0;
    rp   = 45'd0;
    pq   = 43'd0;
    rr   = 43'd0;
    fsum = 64'd0;

    st_d[0].last  = tok_i.last;
    st_d[0].comp  = tok_i.comp;
    st_d[0].ferr  = tok_i.ferr;
    st_d[0].neg   = tok_i.neg;
    st_d[0].ival  = tok_i.ival;
    st_d[0].uval  = tok_i.uval;
    st_d[0].cmul  = tok_i.cmul;
    st_d[0].base  = tok_i.base;
    st_d[0].b9    = tok_i.b9;
    st_d[0].rem   = 43'd0;
    st_d[0].quo   = 12'd0;
    st_d[0].cbase = 42'd0;
    st_d[0].prod  = 63'd0;
    st_d[0].povf  = 1'b0;

    for (int j = 1; j < NumStages; j++) begin
      st_d[j] = st_q[j-1];

      // Integer times unit, one 32x21 partial product per stage.
      if (j <= 4) begin
        ma   = ((j - 1) >= 2) ? {1'b0, st_q[j-1].ival[62:32]} : st_q[j-1].ival[31:0];
        mb   = (((j - 1) % 2) == 1) ? st_q[j-1].uval[41:21] : st_q[j-1].uval[20:0];
        pp   = {21'd0, ma} * {32'd0, mb};
        term = {64'd0, pp} << ((((j - 1) % 2) == 1 ? 21 : 0) + ((j - 1) >= 2 ? 32 : 0));
        acc  = {2'd0, st_q[j-1].prod} + {2'd0, term[62:0]};
        st_d[j].povf = st_q[j-1].povf | (|term[116:63]) | acc[64] | acc[63];
        st_d[j].prod = acc[62:0];
      end

      // The low nine fraction digits times the minute or hour factor.
      if (j == 1) begin
        st_d[j].rem = {31'd0, st_q[j-1].cmul} * {13'd0, st_q[j-1].b9};
      end

      if (j == 2) begin
        st_d[j].cbase = {30'd0, st_q[j-1].cmul} * {12'd0, st_q[j-1].base};
      end

      // Division by 1e9: the estimate from the top dividend bits is at most
      // one below the true quotient, and one compare fixes it.
      if (j == durp_pkg::DivEst) begin
        rp = {23'd0, st_q[j-1].rem[41:20]} * {22'd0, durp_pkg::RecipMul};
        st_d[j].quo = rp[43:32];
      end

      if (j == durp_pkg::DivFix) begin
        pq = {31'd0, st_q[j-1].quo} * durp_pkg::FracDiv;
        rr = st_q[j-1].rem - pq;
        if (rr >= durp_pkg::FracDiv) st_d[j].quo = st_q[j-1].quo + 12'd1;
      end

      if (j == durp_pkg::SumStage) begin
        fsum = {1'b0, st_q[j-1].prod} + {22'd0, st_q[j-1].cbase} + {52'd0, st_q[j-1].quo};
        st_d[j].povf = st_q[j-1].povf | fsum[63];
        st_d[j].prod = fsum[62:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NumStages-2:0], tok_vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q <= st_d;
    end
  end

  assign res_vld_o  = vld_q[NumStages-1];
  assign res_o.last = st_q[NumStages-1].last;
  assign res_o.comp = st_q[NumStages-1].comp;
  assign res_o.ferr = st_q[NumStages-1].ferr;
  assign res_o.neg  = st_q[NumStages-1].neg;
  assign res_o.mag  = st_q[NumStages-1].prod;
  assign res_o.ovf  = st_q[NumStages-1].povf;

endmodule

`default_nettype wire

// File: hw/rtl/durp_accum.sv
`default_nettype none

module durp_accum (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           res_vld_i,
  input  wire durp_pkg::res_t res_i,
  input  wire logic           out_ready_i,
  output logic                adv_o,
  output logic                out_valid_o,
  output logic signed [63:0]  nanoseconds_o,
  output logic [2:0]          status_o
);

  logic [63:0] tot_q, tot_d;
  logic        perr_q, perr_d;
  logic        out_vld_q;
  logic [63:0] ns_q, ns_d;
  logic [2:0]  stat_q, stat_d;
  logic        fire;

  // The pipeline holds only when a finished string meets a full output register.
  assign adv_o = !(res_vld_i && res_i.last && out_vld_q && !out_ready_i);
  assign fire  = adv_o && res_vld_i;

  always_comb begin
    tot_d  = tot_q;
    perr_d = perr_q;
    if (res_i.comp) begin
      if (res_i.ovf) begin
        perr_d = 1'b1;
      end else if (tot_q <= durp_pkg::TopBit) begin
        tot_d = tot_q + {1'b0, res_i.mag};
      end
    end

    ns_d = 64'd0;
    // A scaling overflow always belongs to an earlier component than any
    // parse error, so it is reported first.
    if (perr_d) begin
      stat_d = durp_pkg::StatusSumOvf;
    end else if (res_i.ferr != durp_pkg::StatusOk) begin
      stat_d = res_i.ferr;
    end else if (tot_d > durp_pkg::TopBit || (!res_i.neg && tot_d > durp_pkg::MaxPos)) begin
      stat_d = durp_pkg::StatusSumOvf;
    end else begin
      stat_d = durp_pkg::StatusOk;
      ns_d   = res_i.neg ? (64'd0 - tot_d) : tot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q     <= 64'd0;
      perr_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (fire) begin
        if (res_i.last) begin
          tot_q  <= 64'd0;
          perr_q <= 1'b0;
        end else begin
          tot_q  <= tot_d;
          perr_q <= perr_d;
        end
      end
      if (fire && res_i.last) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_i.last) begin
      ns_q   <= ns_d;
      stat_q <= stat_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign nanoseconds_o = ns_q;
  assign status_o      = stat_q;

endmodule

`default_nettype wire

// File: hw/rtl/durp_checker.sv
`default_nettype none

module durp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] nanoseconds_o,
  input wire logic [2:0]  status_o
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(nanoseconds_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != durp_pkg::StatusOk |-> nanoseconds_o == 64'd0)
    else $error("nonzero duration with error status");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 3'd7)
    else $error("status code out of range");

  // The input side stalls only under output backpressure.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

endmodule

bind duration_string_parser durp_checker u_durp_checker (.*);

`default_nettype wire
